// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, suspended while reset is asserted.
`define TCE_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");

// Clocked assertion that also holds during reset.
`define TCE_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

// File: hw/rtl/tce_pkg.sv
// Types, constants and opcodes of the tiny CPU executor.
package tce_pkg;

    localparam int NUM_REGISTERS = 8;
    localparam int STACK_DEPTH   = 16;

    localparam int REG_AW  = (NUM_REGISTERS > 1) ? $clog2(NUM_REGISTERS) : 1;
    localparam int STK_AW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
    localparam int LEN_W   = 9;
    localparam int ERR_W   = 3;

    localparam logic [LEN_W-1:0] PROGRAM_LENGTH_RESET = 9'd256;

    typedef enum logic [7:0] {
        OP_LOAD  = 8'h01,
        OP_ADD   = 8'h02,
        OP_SUB   = 8'h03,
        OP_STORE = 8'h04,
        OP_NOP   = 8'h05,
        OP_AND   = 8'h06,
        OP_OR    = 8'h07,
        OP_XOR   = 8'h08,
        OP_READ  = 8'h09,
        OP_WRITE = 8'h0A,
        OP_JMP   = 8'h0B,
        OP_CALL  = 8'h0C,
        OP_RET   = 8'h0D,
        OP_BEQ   = 8'h0E,
        OP_BNE   = 8'h0F,
        OP_INT   = 8'h10
    } opcode_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE      = 3'd0,
        ERR_UNKNOWN   = 3'd1,
        ERR_UNDERFLOW = 3'd2,
        ERR_OVERFLOW  = 3'd3,
        ERR_BAD_REG   = 3'd4
    } err_t;

    typedef struct packed {
        logic [7:0] opcode;
        logic [7:0] first_byte;
        logic [7:0] second_byte;
        logic [7:0] key_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0]       next_pc;
        logic             halted;
        logic             store_valid;
        logic [7:0]       store_address;
        logic [7:0]       store_data;
        logic             display_valid;
        logic [7:0]       display_value;
        logic [ERR_W-1:0] error_code;
    } out_item_t;

    // Operands gathered for the execute step.
    typedef struct packed {
        in_item_t         item;
        logic [7:0]       pc;
        logic [LEN_W-1:0] program_length;
        logic [7:0]       reg_rd;
        logic [7:0]       reg0;
        logic [7:0]       reg1;
        logic [7:0]       stack_top;
        logic [DEPTH_W-1:0] depth;
    } exec_in_t;

    // State updates requested by the execute step.
    typedef struct packed {
        logic              reg_we;
        logic [REG_AW-1:0] reg_waddr;
        logic [7:0]        reg_wdata;
        logic              push;
        logic              pop;
        logic [7:0]        stack_wdata;
    } exec_upd_t;

endpackage

// File: hw/rtl/tce_exec.sv
// Decode, ALU and next-pc logic of one instruction.
module tce_exec (
    input  tce_pkg::exec_in_t  ex_in,
    output tce_pkg::out_item_t res,
    output tce_pkg::exec_upd_t upd
);

    logic [7:0]  pc;
    logic [7:0]  b1;
    logic [7:0]  b2;
    logic [7:0]  npc;
    logic        reg_ok;
    logic        full;
    logic        empty;
    logic        eq;
    tce_pkg::err_t err;

    assign pc     = ex_in.pc;
    assign b1     = ex_in.item.first_byte;
    assign b2     = ex_in.item.second_byte;
    assign reg_ok = {1'b0, b1} < tce_pkg::LEN_W'(tce_pkg::NUM_REGISTERS);
    assign full   = ex_in.depth >= tce_pkg::DEPTH_W'(tce_pkg::STACK_DEPTH);
    assign empty  = ex_in.depth == '0;
    assign eq     = ex_in.reg0 == ex_in.reg1;

    always_comb begin
        npc                 = pc;
        err                 = tce_pkg::ERR_NONE;
        upd.reg_we          = 1'b0;
        upd.reg_waddr       = b1[tce_pkg::REG_AW-1:0];
        upd.reg_wdata       = b2;
        upd.push            = 1'b0;
        upd.pop             = 1'b0;
        upd.stack_wdata     = pc + 8'd2;
        res.store_valid     = 1'b0;
        res.store_address   = '0;
        res.store_data      = '0;
        res.display_valid   = 1'b0;
        res.display_value   = '0;

        if ({1'b0, pc} < ex_in.program_length) begin
            unique case (tce_pkg::opcode_t'(ex_in.item.opcode))
                tce_pkg::OP_LOAD, tce_pkg::OP_ADD, tce_pkg::OP_SUB,
                tce_pkg::OP_AND, tce_pkg::OP_OR, tce_pkg::OP_XOR: begin
                    npc = pc + 8'd3;
                    if (!reg_ok) begin
                        err = tce_pkg::ERR_BAD_REG;
                    end else begin
                        upd.reg_we = 1'b1;
                        unique case (tce_pkg::opcode_t'(ex_in.item.opcode))
                            tce_pkg::OP_ADD: upd.reg_wdata = ex_in.reg_rd + b2;
                            tce_pkg::OP_SUB: upd.reg_wdata = ex_in.reg_rd - b2;
                            tce_pkg::OP_AND: upd.reg_wdata = ex_in.reg_rd & b2;
                            tce_pkg::OP_OR:  upd.reg_wdata = ex_in.reg_rd | b2;
                            tce_pkg::OP_XOR: upd.reg_wdata = ex_in.reg_rd ^ b2;
                            default:         upd.reg_wdata = b2;
                        endcase
                    end
                end
                tce_pkg::OP_STORE: begin
                    npc = pc + 8'd3;
                    if (!reg_ok) begin
                        err = tce_pkg::ERR_BAD_REG;
                    end else begin
                        res.store_valid   = 1'b1;
                        res.store_address = b2;
                        res.store_data    = ex_in.reg_rd;
                    end
                end
                tce_pkg::OP_NOP: npc = pc + 8'd1;
                tce_pkg::OP_READ: begin
                    npc = pc + 8'd2;
                    if (!reg_ok) begin
                        err = tce_pkg::ERR_BAD_REG;
                    end else begin
                        upd.reg_we    = 1'b1;
                        upd.reg_wdata = ex_in.item.key_byte;
                    end
                end
                tce_pkg::OP_WRITE: begin
                    npc = pc + 8'd2;
                    if (!reg_ok) begin
                        err = tce_pkg::ERR_BAD_REG;
                    end else begin
                        res.display_valid = 1'b1;
                        res.display_value = ex_in.reg_rd;
                    end
                end
                tce_pkg::OP_JMP: npc = b1;
                tce_pkg::OP_CALL: begin
                    if (full) begin
                        err = tce_pkg::ERR_OVERFLOW;
                        npc = pc + 8'd2;
                    end else begin
                        upd.push = 1'b1;
                        npc      = b1;
                    end
                end
                tce_pkg::OP_RET: begin
                    if (empty) begin
                        err = tce_pkg::ERR_UNDERFLOW;
                        npc = pc + 8'd1;
                    end else begin
                        upd.pop = 1'b1;
                        npc     = ex_in.stack_top;
                    end
                end
                tce_pkg::OP_BEQ: npc = eq ? b1 : pc + 8'd2;
                tce_pkg::OP_BNE: npc = eq ? pc + 8'd2 : b1;
                tce_pkg::OP_INT: npc = pc + 8'd2;
                default: begin
                    err = tce_pkg::ERR_UNKNOWN;
                    npc = pc + 8'd1;
                end
            endcase
        end

        res.next_pc    = npc;
        res.halted     = {1'b0, npc} >= ex_in.program_length;
        res.error_code = err;
    end

endmodule

// File: hw/rtl/tiny_8bit_cpu_executor.sv
// Top level of the tiny CPU executor: operand memories, pipeline and output register.
//
// Input channel s_valid/s_ready/s_data carries one instruction item: opcode, the
// two bytes after it and a keyboard byte. Output channel m_valid/m_ready/m_data
// returns one result item per instruction: new pc, halt flag, optional store,
// optional display write and an error code.
// Pipeline: the accepting edge reads the register file and return stack (synchronous
// memories) into the execute stage; execute and write-back happen at the edge that
// moves the item into the output register, which waits while the output is stalled.
// Throughput: 1 item per cycle while the output is not stalled, set by the single
// read-modify-write of the register file and stack per instruction; same-entry
// overlaps between neighbors are forwarded.
// cfg_wr_en/cfg_wr_data write program_length (reset 256); write only while idle.
// Reset clears pc, stack depth, register-file valid bits and both pipeline
// stages; unwritten register-file entries read as zero. When m_ready is low the result
// holds, one more item is taken into an empty execute stage, then s_ready drops.
module tiny_8bit_cpu_executor (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  tce_pkg::in_item_t          s_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output tce_pkg::out_item_t         m_data,
    input  logic                       cfg_wr_en,
    input  logic [tce_pkg::LEN_W-1:0]  cfg_wr_data
);

    logic [7:0]                   regmem   [tce_pkg::NUM_REGISTERS];
    logic [7:0]                   stackmem [tce_pkg::STACK_DEPTH];

    logic [7:0]                   pc_reg;
    logic [tce_pkg::LEN_W-1:0]    len_reg;
    logic [tce_pkg::DEPTH_W-1:0]  depth_reg;
    logic [tce_pkg::DEPTH_W-1:0]  depth_next;
    logic [7:0]                   r0_reg;
    logic [7:0]                   r1_reg;
    logic [tce_pkg::NUM_REGISTERS-1:0] rvalid_reg;

    logic                         s1_valid_reg;
    tce_pkg::in_item_t            s1_item_reg;
    logic [7:0]                   reg_q_reg;
    logic                         reg_qv_reg;
    logic                         reg_fwd_reg;
    logic [7:0]                   reg_fwd_data_reg;
    logic [7:0]                   stk_q_reg;
    logic                         stk_fwd_reg;
    logic [7:0]                   stk_fwd_data_reg;

    logic                         m_valid_reg;
    tce_pkg::out_item_t           m_data_reg;

    logic                         exec_fire;
    logic                         s_fire;
    logic [tce_pkg::REG_AW-1:0]   reg_raddr;
    logic [tce_pkg::DEPTH_W-1:0]  depth_eff;
    logic [tce_pkg::DEPTH_W-1:0]  depth_dec;
    logic [tce_pkg::STK_AW-1:0]   stk_raddr;
    logic [tce_pkg::STK_AW-1:0]   stk_waddr;

    tce_pkg::exec_in_t            ex_in;
    tce_pkg::out_item_t           ex_res;
    tce_pkg::exec_upd_t           ex_upd;

    assign exec_fire = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready   = !s1_valid_reg || exec_fire;
    assign s_fire    = s_valid && s_ready;

    assign reg_raddr = s_data.first_byte[tce_pkg::REG_AW-1:0];

    always_comb begin
        depth_next = depth_reg;
        if (ex_upd.push) begin
            depth_next = depth_reg + tce_pkg::DEPTH_W'(1);
        end else if (ex_upd.pop) begin
            depth_next = depth_reg - tce_pkg::DEPTH_W'(1);
        end
    end

    // Stack top address seen by the incoming item, after the one in execute.
    assign depth_eff = exec_fire ? depth_next : depth_reg;
    assign depth_dec = depth_eff - tce_pkg::DEPTH_W'(1);
    assign stk_raddr = depth_dec[tce_pkg::STK_AW-1:0];
    assign stk_waddr = depth_reg[tce_pkg::STK_AW-1:0];

    always_comb begin
        ex_in.item           = s1_item_reg;
        ex_in.pc             = pc_reg;
        ex_in.program_length = len_reg;
        ex_in.reg_rd         = reg_fwd_reg ? reg_fwd_data_reg
                                           : (reg_qv_reg ? reg_q_reg : 8'd0);
        ex_in.reg0           = r0_reg;
        ex_in.reg1           = r1_reg;
        ex_in.stack_top      = stk_fwd_reg ? stk_fwd_data_reg : stk_q_reg;
        ex_in.depth          = depth_reg;
    end

    tce_exec u_exec (
        .ex_in (ex_in),
        .res   (ex_res),
        .upd   (ex_upd)
    );

    // Register file memory.
    always_ff @(posedge aclk) begin
        if (exec_fire && ex_upd.reg_we) begin
            regmem[ex_upd.reg_waddr] <= ex_upd.reg_wdata;
        end
        if (s_fire) begin
            reg_q_reg <= regmem[reg_raddr];
        end
    end

    // Return stack memory.
    always_ff @(posedge aclk) begin
        if (exec_fire && ex_upd.push) begin
            stackmem[stk_waddr] <= ex_upd.stack_wdata;
        end
        if (s_fire) begin
            stk_q_reg <= stackmem[stk_raddr];
        end
    end

    // Payload and forwarding captured with each accepted item; result register loaded on execute.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s1_item_reg      <= s_data;
            reg_qv_reg       <= rvalid_reg[reg_raddr];
            reg_fwd_reg      <= exec_fire && ex_upd.reg_we && (ex_upd.reg_waddr == reg_raddr);
            reg_fwd_data_reg <= ex_upd.reg_wdata;
            stk_fwd_reg      <= exec_fire && ex_upd.push && (stk_waddr == stk_raddr);
            stk_fwd_data_reg <= ex_upd.stack_wdata;
        end
        if (exec_fire) begin
            m_data_reg <= ex_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg       <= '0;
            len_reg      <= tce_pkg::PROGRAM_LENGTH_RESET;
            depth_reg    <= '0;
            r0_reg       <= '0;
            r1_reg       <= '0;
            rvalid_reg   <= '0;
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                len_reg <= cfg_wr_data;
            end
            if (s_fire) begin
                s1_valid_reg <= 1'b1;
            end else if (exec_fire) begin
                s1_valid_reg <= 1'b0;
            end
            if (exec_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (exec_fire) begin
                pc_reg    <= ex_res.next_pc;
                depth_reg <= depth_next;
                if (ex_upd.reg_we) begin
                    rvalid_reg[ex_upd.reg_waddr] <= 1'b1;
                    // r0/r1 shadows feed the branch compare
                    if (ex_upd.reg_waddr == tce_pkg::REG_AW'(0)) begin
                        r0_reg <= ex_upd.reg_wdata;
                    end
                    if (ex_upd.reg_waddr == tce_pkg::REG_AW'(1)) begin
                        r1_reg <= ex_upd.reg_wdata;
                    end
                end
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// File: hw/rtl/tce_checker.sv
// Port-level assertions for the tiny CPU executor, bound to the top level.
`include "assert_macros.svh"

module tce_checker (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_valid,
    input logic                      s_ready,
    input tce_pkg::in_item_t         s_data,
    input logic                      m_valid,
    input logic                      m_ready,
    input tce_pkg::out_item_t        m_data,
    input logic                      cfg_wr_en,
    input logic [tce_pkg::LEN_W-1:0] cfg_wr_data
);

    logic [tce_pkg::LEN_W-1:0] len_reg;
    logic                      in_seen;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= tce_pkg::PROGRAM_LENGTH_RESET;
        end else if (cfg_wr_en) begin
            len_reg <= cfg_wr_data;
        end
    end

    assign in_seen = s_valid || s_ready || (s_data != '0);

    `TCE_ASSERT(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid)
    `TCE_ASSERT(a_out_stable, aclk, aresetn, m_valid && !m_ready |=> $stable(m_data))
    // no item both stores and displays, and an erroring item does neither
    `TCE_ASSERT(a_side_effects, aclk, aresetn,
        m_valid |-> !(m_data.store_valid && m_data.display_valid) &&
        ((m_data.error_code == tce_pkg::ERR_NONE) ||
         (!m_data.store_valid && !m_data.display_valid)))
    `TCE_ASSERT(a_halt_flag, aclk, aresetn,
        m_valid && in_seen |-> m_data.halted == ({1'b0, m_data.next_pc} >= len_reg))
    `TCE_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_valid)

endmodule

bind tiny_8bit_cpu_executor tce_checker u_tce_checker (.*);

// File: tb/sv/tb.sv
// Self-checking testbench for the tiny 8-bit CPU executor.
`timescale 1ns / 1ps

module tb;
    import tce_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int MAX_PRINTED = 20;
    // opcode bytes outside the instruction set
    localparam logic [7:0] OP_BAD_ZERO = 8'h00;
    localparam logic [7:0] OP_BAD_NEXT = 8'h11;
    localparam logic [7:0] OP_BAD_TOP  = 8'hFF;

    logic             aclk;
    logic             aresetn;
    logic             s_valid = 1'b0;
    logic             s_ready;
    in_item_t         s_data = '0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    out_item_t        m_data;
    logic             cfg_wr_en = 1'b0;
    logic [LEN_W-1:0] cfg_wr_data = '0;

    tiny_8bit_cpu_executor dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // architectural state tracked by the predictor
    logic [7:0]       cpu_pc;
    logic [7:0]       cpu_regs [NUM_REGISTERS];
    logic [7:0]       ret_addrs [STACK_DEPTH];
    int unsigned      ret_depth;
    logic [LEN_W-1:0] prog_len;

    in_item_t  instr_queue[$];
    out_item_t predicted_results[$];
    out_item_t oldest_result;

    int errors;
    int cycle_count;
    int instr_count;
    int result_count;
    int setting_count;
    int store_count;
    int display_count;
    int flagged_count;
    int halted_count;
    int burst_left;
    int gap_left;
    int ready_tick;

    opcode_t all_ops [16] = '{OP_LOAD, OP_ADD, OP_SUB, OP_STORE, OP_NOP, OP_AND, OP_OR,
                              OP_XOR, OP_READ, OP_WRITE, OP_JMP, OP_CALL, OP_RET, OP_BEQ,
                              OP_BNE, OP_INT};

    initial begin
        cpu_pc    = '0;
        ret_depth = 0;
        prog_len  = PROGRAM_LENGTH_RESET;
        for (int i = 0; i < NUM_REGISTERS; i++) cpu_regs[i] = '0;
        for (int i = 0; i < STACK_DEPTH; i++) ret_addrs[i] = '0;
    end

    // Executes one instruction on the tracked state and returns its result.
    function automatic out_item_t execute_instruction(in_item_t it);
        out_item_t         res;
        logic [7:0]        pc;
        logic [7:0]        npc;
        logic [7:0]        cur;
        logic [7:0]        val;
        logic [REG_AW-1:0] idx;
        logic              reg_ok;
        logic              take;
        res    = '0;
        pc     = cpu_pc;
        npc    = pc;
        idx    = it.first_byte[REG_AW-1:0];
        reg_ok = it.first_byte < NUM_REGISTERS;
        if ({1'b0, pc} < prog_len) begin
            case (it.opcode)
                OP_LOAD, OP_ADD, OP_SUB, OP_AND, OP_OR, OP_XOR: begin
                    npc = pc + 8'd3;
                    if (!reg_ok) begin
                        res.error_code = ERR_BAD_REG;
                    end else begin
                        cur = cpu_regs[idx];
                        case (it.opcode)
                            OP_LOAD: val = it.second_byte;
                            OP_ADD:  val = cur + it.second_byte;
                            OP_SUB:  val = cur - it.second_byte;
                            OP_AND:  val = cur & it.second_byte;
                            OP_OR:   val = cur | it.second_byte;
                            default: val = cur ^ it.second_byte;
                        endcase
                        cpu_regs[idx] = val;
                    end
                end
                OP_STORE: begin
                    npc = pc + 8'd3;
                    if (!reg_ok) begin
                        res.error_code = ERR_BAD_REG;
                    end else begin
                        res.store_valid   = 1'b1;
                        res.store_address = it.second_byte;
                        res.store_data    = cpu_regs[idx];
                    end
                end
                OP_NOP: npc = pc + 8'd1;
                OP_READ: begin
                    npc = pc + 8'd2;
                    if (!reg_ok) res.error_code = ERR_BAD_REG;
                    else cpu_regs[idx] = it.key_byte;
                end
                OP_WRITE: begin
                    npc = pc + 8'd2;
                    if (!reg_ok) begin
                        res.error_code = ERR_BAD_REG;
                    end else begin
                        res.display_valid = 1'b1;
                        res.display_value = cpu_regs[idx];
                    end
                end
                OP_JMP: npc = it.first_byte;
                OP_CALL: begin
                    if (ret_depth >= STACK_DEPTH) begin
                        res.error_code = ERR_OVERFLOW;
                        npc = pc + 8'd2;
                    end else begin
                        ret_addrs[ret_depth] = pc + 8'd2;
                        ret_depth++;
                        npc = it.first_byte;
                    end
                end
                OP_RET: begin
                    if (ret_depth == 0) begin
                        res.error_code = ERR_UNDERFLOW;
                        npc = pc + 8'd1;
                    end else begin
                        ret_depth--;
                        npc = ret_addrs[ret_depth];
                    end
                end
                OP_BEQ, OP_BNE: begin
                    take = (cpu_regs[0] == cpu_regs[1]) ^ (it.opcode == OP_BNE);
                    npc  = take ? it.first_byte : pc + 8'd2;
                end
                OP_INT: npc = pc + 8'd2;
                default: begin
                    res.error_code = ERR_UNKNOWN;
                    npc = pc + 8'd1;
                end
            endcase
        end
        cpu_pc      = npc;
        res.next_pc = npc;
        res.halted  = {1'b0, npc} >= prog_len;
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        if (errors < MAX_PRINTED) $display("[%0t] result %0d: %s", $time, result_count, msg);
        errors++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h, predicted %0h", name, got, want));
    endtask

    // sender: bursts of items separated by random gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid    <= 1'b0;
            burst_left = 1;
            gap_left   = 0;
        end else begin
            if (s_valid && s_ready) begin
                predicted_results = {predicted_results, execute_instruction(s_data)};
                instr_count++;
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (instr_queue.size() > 0) begin
                    s_valid <= 1'b1;
                    s_data  <= instr_queue.pop_front();
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: checks results and stalls in changing modes
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            ready_tick = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (predicted_results.size() == 0) begin
                    report_mismatch("result with nothing predicted");
                end else begin
                    oldest_result = predicted_results.pop_front();
                    check_field("next_pc", m_data.next_pc, oldest_result.next_pc);
                    check_field("halted", m_data.halted, oldest_result.halted);
                    check_field("store_valid", m_data.store_valid, oldest_result.store_valid);
                    check_field("store_address", m_data.store_address,
                                oldest_result.store_address);
                    check_field("store_data", m_data.store_data, oldest_result.store_data);
                    check_field("display_valid", m_data.display_valid,
                                oldest_result.display_valid);
                    check_field("display_value", m_data.display_value,
                                oldest_result.display_value);
                    check_field("error_code", m_data.error_code, oldest_result.error_code);
                    store_count   += oldest_result.store_valid;
                    display_count += oldest_result.display_valid;
                    halted_count  += oldest_result.halted;
                    if (oldest_result.error_code != ERR_NONE) flagged_count++;
                end
                result_count++;
            end
            ready_tick++;
            case ((ready_tick / 400) % 4)
                0:       m_ready <= 1'b1;
                1:       m_ready <= ($urandom_range(0, 1) == 1);
                2:       m_ready <= (ready_tick % 5) != 0;
                default: m_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results pending", cycle_count,
                     predicted_results.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic push_instr(input logic [7:0] op, input logic [7:0] b1,
                              input logic [7:0] b2, input logic [7:0] key);
        in_item_t it;
        it.opcode      = op;
        it.first_byte  = b1;
        it.second_byte = b2;
        it.key_byte    = key;
        instr_queue = {instr_queue, it};
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        while (instr_queue.size() != 0 || s_valid || predicted_results.size() != 0)
            @(negedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic set_program_length(input logic [LEN_W-1:0] len);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= len;
        prog_len    = len;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        setting_count++;
    endtask

    // a well-formed instruction with a valid register index most of the time
    task automatic push_random_op();
        logic [7:0] op;
        logic [7:0] b1;
        op = all_ops[$urandom_range(0, 15)];
        if (op inside {OP_LOAD, OP_ADD, OP_SUB, OP_STORE, OP_AND, OP_OR, OP_XOR, OP_READ,
                       OP_WRITE})
            b1 = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(0, 255))
                                               : 8'($urandom_range(0, NUM_REGISTERS - 1));
        else
            b1 = 8'($urandom_range(0, 255));
        push_instr(op, b1, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    endtask

    task automatic push_random_sequence();
        int         depth;
        logic [7:0] v;
        logic [7:0] r;
        case ($urandom_range(0, 9))
            5: begin
                // nested calls, deep enough at times to overflow, then unwind, at times past empty
                depth = $urandom_range(1, 18);
                for (int i = 0; i < depth; i++) begin
                    if ($urandom_range(0, 2) == 0) push_random_op();
                    push_instr(OP_CALL, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                               8'($urandom_range(0, 255)));
                end
                for (int i = 0; i < depth + int'($urandom_range(0, 2)); i++)
                    push_instr(OP_RET, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                               8'($urandom_range(0, 255)));
            end
            6: begin
                v = 8'($urandom_range(0, 255));
                push_instr(OP_LOAD, 8'd0, v, 8'($urandom_range(0, 255)));
                push_instr(OP_LOAD, 8'd1, $urandom_range(0, 1) ? v : 8'($urandom_range(0, 255)),
                           8'($urandom_range(0, 255)));
                push_instr($urandom_range(0, 1) ? OP_BEQ : OP_BNE, 8'($urandom_range(0, 255)),
                           8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            end
            7: begin
                r = 8'($urandom_range(0, NUM_REGISTERS - 1));
                push_instr(OP_READ, r, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                for (int i = 0; i < int'($urandom_range(1, 4)); i++)
                    push_instr(all_ops[$urandom_range(0, 2)], r, 8'($urandom_range(0, 255)),
                               8'($urandom_range(0, 255)));
                push_instr(OP_STORE, r, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                push_instr(OP_WRITE, r, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            end
            8: push_instr(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            9: push_instr(all_ops[$urandom_range(0, 9)], 8'($urandom_range(NUM_REGISTERS, 255)),
                          8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            default: push_random_op();
        endcase
    endtask

    task automatic run_phase(input logic [LEN_W-1:0] len, input int count);
        wait_idle();
        set_program_length(len);
        @(negedge aclk);
        while (instr_queue.size() < count) push_random_sequence();
    endtask

    // a length a little past the current pc, so the program halts partway through
    function automatic logic [LEN_W-1:0] length_near_pc();
        int v;
        v = int'(cpu_pc) + int'($urandom_range(4, 60));
        if (v > 256) v = 256;
        return LEN_W'(v);
    endfunction

    initial begin
        aresetn = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        wait_idle();
        set_program_length(PROGRAM_LENGTH_RESET);
        @(negedge aclk);
        push_instr(OP_LOAD, 8'd0, 8'hFF, 8'h00);
        push_instr(OP_LOAD, 8'd7, 8'h00, 8'hFF);
        push_instr(OP_ADD, 8'd0, 8'h01, 8'h00);   // wraps to zero
        push_instr(OP_SUB, 8'd7, 8'h01, 8'h00);   // wraps to all ones
        push_instr(OP_AND, 8'd7, 8'h5A, 8'h00);
        push_instr(OP_OR, 8'd0, 8'hA5, 8'h00);
        push_instr(OP_XOR, 8'd7, 8'hFF, 8'h00);
        push_instr(OP_STORE, 8'd7, 8'hFF, 8'h00);
        push_instr(OP_WRITE, 8'd0, 8'h00, 8'h00);
        push_instr(OP_READ, 8'd3, 8'h00, 8'hFF);
        push_instr(OP_WRITE, 8'd3, 8'h00, 8'h00);
        push_instr(OP_NOP, 8'h00, 8'h00, 8'h00);
        push_instr(OP_INT, 8'hFF, 8'hFF, 8'hFF);
        push_instr(OP_RET, 8'h00, 8'h00, 8'h00);  // empty stack
        push_instr(OP_CALL, 8'h80, 8'h00, 8'h00);
        push_instr(OP_RET, 8'h00, 8'h00, 8'h00);
        push_instr(OP_BEQ, 8'h40, 8'h00, 8'h00);  // r0 != r1, falls through
        push_instr(OP_BNE, 8'hF0, 8'h00, 8'h00);
        push_instr(OP_JMP, 8'hFE, 8'h00, 8'h00);
        push_instr(OP_INT, 8'h00, 8'h00, 8'h00);  // pc wraps past the top
        push_instr(OP_LOAD, 8'd8, 8'h12, 8'h00);
        push_instr(OP_STORE, 8'hFF, 8'h34, 8'h00);
        push_instr(OP_READ, 8'h80, 8'h00, 8'h56);
        push_instr(OP_WRITE, 8'd8, 8'h00, 8'h00);
        push_instr(OP_BAD_ZERO, 8'h00, 8'h00, 8'h00);
        push_instr(OP_BAD_TOP, 8'hFF, 8'hFF, 8'hFF);
        push_instr(OP_BAD_NEXT, 8'h00, 8'h00, 8'h00);
        push_instr(OP_LOAD, 8'd1, 8'hA5, 8'h00);
        push_instr(OP_BEQ, 8'h20, 8'h00, 8'h00);  // now equal, taken

        run_phase(PROGRAM_LENGTH_RESET, 300);
        run_phase(9'd511, 250);
        wait_idle();
        run_phase(length_near_pc(), 80);
        run_phase(9'd0, 40);
        run_phase(PROGRAM_LENGTH_RESET, 250);
        run_phase(9'd1, 40);
        wait_idle();
        run_phase(length_near_pc(), 80);
        run_phase(LEN_W'($urandom_range(257, 510)), 250);
        run_phase(PROGRAM_LENGTH_RESET, 300);

        wait_idle();
        repeat (10) @(posedge aclk);
        if (predicted_results.size() != 0)
            report_mismatch($sformatf("%0d predicted results never came",
                                      predicted_results.size()));
        $display("Ran %0d instructions under %0d program-length settings, %0d results checked",
                 instr_count, setting_count, result_count);
        $display("Seen %0d stores, %0d displays, %0d flagged, %0d halted, %0d mismatches",
                 store_count, display_count, flagged_count, halted_count, errors);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
